FILE: src/nbg_pkg.sv
package nbg_pkg;

    localparam int NUM_BODIES_DEF = 32;
    localparam int OUT_LIMIT      = 32;
    localparam int IDX_IN_W       = 5;
    localparam int DT_W           = 17;
    localparam int SOFT_W         = 31;
    localparam int MASS_W         = 31;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 32;
    localparam int TERM_W         = 58;

    localparam logic [DT_W-1:0]   DT_RESET   = 17'd6554;
    localparam logic [SOFT_W-1:0] SOFT_RESET = 31'd655360;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_STEP = 1'b0,
        REG_SOFTENING = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [MASS_W-1:0]  mass;
    } body_t;

    typedef struct packed {
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
    } accel_t;

    typedef struct packed {
        logic signed [31:0] pix;
        logic signed [31:0] piy;
        logic signed [31:0] pjx;
        logic signed [31:0] pjy;
        logic [MASS_W-1:0]  mass;
    } pair_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pair_stat_t;

    typedef struct packed {
        logic signed [TERM_W-1:0] term_x;
        logic signed [TERM_W-1:0] term_y;
    } pair_res_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

FILE: src/nbg_if.sv
interface nbg_in_if;
    import nbg_pkg::*;
    logic                valid;
    logic                ready;
    logic                opcode;
    logic [IDX_IN_W-1:0] body_index;
    logic signed [31:0]  pos_x;
    logic signed [31:0]  pos_y;
    logic signed [31:0]  vel_x;
    logic signed [31:0]  vel_y;
    logic [MASS_W-1:0]   mass;

    modport source (output valid, opcode, body_index, pos_x, pos_y, vel_x, vel_y, mass,
                    input ready);
    modport sink (input valid, opcode, body_index, pos_x, pos_y, vel_x, vel_y, mass,
                  output ready);
endinterface

interface nbg_out_if;
    import nbg_pkg::*;
    logic                valid;
    logic                ready;
    logic [IDX_IN_W-1:0] out_index;
    logic signed [31:0]  new_pos_x;
    logic signed [31:0]  new_pos_y;
    logic signed [31:0]  accel_x;
    logic signed [31:0]  accel_y;
    logic signed [31:0]  new_vel_x;
    logic signed [31:0]  new_vel_y;
    logic                last;

    modport source (output valid, out_index, new_pos_x, new_pos_y, accel_x, accel_y,
                    new_vel_x, new_vel_y, last, input ready);
    modport sink (input valid, out_index, new_pos_x, new_pos_y, accel_x, accel_y,
                  new_vel_x, new_vel_y, last, output ready);
endinterface

interface nbg_cfg_if;
    import nbg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: src/nbg_body_mem.sv
module nbg_body_mem
    import nbg_pkg::*;
#(
    parameter int NUM_BODIES = NUM_BODIES_DEF
)
(
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(NUM_BODIES)-1:0] wr_addr,
    input  body_t                         wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(NUM_BODIES)-1:0] rd_addr,
    output body_t                         rd_data
);

    body_t mem [NUM_BODIES];
    body_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/nbg_accel_mem.sv
module nbg_accel_mem
    import nbg_pkg::*;
#(
    parameter int NUM_BODIES = NUM_BODIES_DEF
)
(
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(NUM_BODIES)-1:0] wr_addr,
    input  accel_t                        wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(NUM_BODIES)-1:0] rd_addr,
    output accel_t                        rd_data
);

    accel_t mem [NUM_BODIES];
    accel_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/nbg_pair_unit.sv
module nbg_pair_unit
    import nbg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  pair_req_t         req,
    input  logic [SOFT_W-1:0] softening,
    output pair_stat_t        stat,
    output pair_res_t         res
);

    typedef enum logic [11:0] {
        P_IDLE  = 12'b0000_0000_0001,
        P_ABS   = 12'b0000_0000_0010,
        P_SQ    = 12'b0000_0000_0100,
        P_SUM   = 12'b0000_0000_1000,
        P_SQRT  = 12'b0000_0001_0000,
        P_R     = 12'b0000_0010_0000,
        P_CUBE1 = 12'b0000_0100_0000,
        P_CUBE2 = 12'b0000_1000_0000,
        P_CUBE3 = 12'b0001_0000_0000,
        P_CUBE4 = 12'b0010_0000_0000,
        P_DIV   = 12'b0100_0000_0000,
        P_DONE  = 12'b1000_0000_0000
    } pstate_t;

    localparam logic [94:0] Q_LIMIT = 95'd1 << 56;

    pstate_t state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;

    logic signed [32:0] dx_reg, dy_reg;
    logic [MASS_W-1:0]  mass_reg;
    logic [31:0]        ax_reg, ay_reg;
    logic               negx_reg, negy_reg, big_reg;
    logic [30:0]        opx_reg, opy_reg;
    logic [61:0]        sqx_reg, sqy_reg;
    logic [63:0]        v_reg, root_reg, bit_reg;
    logic [33:0]        r_reg;
    logic [67:0]        r2_reg, p0_reg, p1_reg;
    logic [101:0]       d_reg;
    logic [94:0]        dvdx_reg, dvdy_reg, qx_reg, qy_reg;
    logic [101:0]       remx_reg, remy_reg;

    // magnitudes of the displacement
    logic [32:0] ndx, ndy;
    logic [31:0] ax_c, ay_c;
    logic        big_c;
    assign ndx   = -dx_reg;
    assign ndy   = -dy_reg;
    assign ax_c  = dx_reg[32] ? ndx[31:0] : dx_reg[31:0];
    assign ay_c  = dy_reg[32] ? ndy[31:0] : dy_reg[31:0];
    assign big_c = ax_c[31] | ay_c[31];

    // floor square root, one result bit a cycle
    logic [63:0] sq_trial;
    logic        sq_ge;
    logic [32:0] pair_len;
    assign sq_trial = root_reg + bit_reg;
    assign sq_ge    = v_reg >= sq_trial;
    assign pair_len = big_reg ? {root_reg[31:0], 1'b0} : {1'b0, root_reg[31:0]};

    logic [62:0] nx, ny;
    assign nx = 63'(ax_reg) * 63'(mass_reg);
    assign ny = 63'(ay_reg) * 63'(mass_reg);

    // restoring division, x and y share the divisor
    logic [102:0] shx, shy, subx, suby;
    logic         gex, gey;
    assign shx  = {remx_reg, dvdx_reg[94]};
    assign shy  = {remy_reg, dvdy_reg[94]};
    assign gex  = shx >= {1'b0, d_reg};
    assign gey  = shy >= {1'b0, d_reg};
    assign subx = shx - {1'b0, d_reg};
    assign suby = shy - {1'b0, d_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            P_IDLE:  if (start) state_next = P_ABS;
            P_ABS:   state_next = P_SQ;
            P_SQ:    state_next = P_SUM;
            P_SUM:
            begin
                cnt_next   = '0;
                state_next = P_SQRT;
            end
            P_SQRT:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd31)
                    state_next = P_R;
            end
            P_R:     state_next = P_CUBE1;
            P_CUBE1: state_next = (r_reg == '0) ? P_DONE : P_CUBE2;
            P_CUBE2: state_next = P_CUBE3;
            P_CUBE3: state_next = P_CUBE4;
            P_CUBE4:
            begin
                cnt_next   = '0;
                state_next = P_DIV;
            end
            P_DIV:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd94)
                    state_next = P_DONE;
            end
            P_DONE:  state_next = P_IDLE;
            default: state_next = P_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            P_IDLE:
            begin
                dx_reg   <= {req.pjx[31], req.pjx} - {req.pix[31], req.pix};
                dy_reg   <= {req.pjy[31], req.pjy} - {req.piy[31], req.piy};
                mass_reg <= req.mass;
            end
            P_ABS:
            begin
                ax_reg   <= ax_c;
                ay_reg   <= ay_c;
                negx_reg <= dx_reg[32];
                negy_reg <= dy_reg[32];
                big_reg  <= big_c;
                opx_reg  <= big_c ? ax_c[31:1] : ax_c[30:0];
                opy_reg  <= big_c ? ay_c[31:1] : ay_c[30:0];
            end
            P_SQ:
            begin
                sqx_reg <= 62'(opx_reg) * 62'(opx_reg);
                sqy_reg <= 62'(opy_reg) * 62'(opy_reg);
            end
            P_SUM:
            begin
                v_reg    <= 64'(sqx_reg) + 64'(sqy_reg);
                root_reg <= '0;
                bit_reg  <= 64'd1 << 62;
            end
            P_SQRT:
            begin
                if (sq_ge)
                begin
                    v_reg    <= v_reg - sq_trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                    root_reg <= root_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            P_R:
                r_reg <= 34'(pair_len) + 34'(softening);
            P_CUBE1:
            begin
                if (r_reg == '0)
                begin
                    qx_reg <= '0;
                    qy_reg <= '0;
                end
                r2_reg   <= 68'(r_reg) * 68'(r_reg);
                dvdx_reg <= {nx, 32'd0};
                dvdy_reg <= {ny, 32'd0};
                remx_reg <= '0;
                remy_reg <= '0;
            end
            P_CUBE2: p0_reg <= 68'(r2_reg[33:0]) * 68'(r_reg);
            P_CUBE3: p1_reg <= 68'(r2_reg[67:34]) * 68'(r_reg);
            P_CUBE4: d_reg  <= {p1_reg, 34'd0} + 102'(p0_reg);
            P_DIV:
            begin
                remx_reg <= gex ? subx[101:0] : shx[101:0];
                remy_reg <= gey ? suby[101:0] : shy[101:0];
                dvdx_reg <= {dvdx_reg[93:0], 1'b0};
                dvdy_reg <= {dvdy_reg[93:0], 1'b0};
                qx_reg   <= {qx_reg[93:0], gex};
                qy_reg   <= {qy_reg[93:0], gey};
            end
            default: ;
        endcase
    end

    // saturate magnitude at 2^56 and restore the sign
    logic [56:0] magx, magy;
    logic [57:0] posx, posy;
    assign magx = (qx_reg > Q_LIMIT) ? Q_LIMIT[56:0] : qx_reg[56:0];
    assign magy = (qy_reg > Q_LIMIT) ? Q_LIMIT[56:0] : qy_reg[56:0];
    assign posx = {1'b0, magx};
    assign posy = {1'b0, magy};

    assign res.term_x = negx_reg ? -posx : posx;
    assign res.term_y = negy_reg ? -posy : posy;
    assign stat.busy  = state_reg != P_IDLE;
    assign stat.done  = state_reg == P_DONE;

endmodule

FILE: src/nbody_gravity_euler_step_core.sv
// channel | dir | payload                                               | transfer
// cfg     | in  | index (0 time_step, 1 softening), data                | valid & ready
// cmd     | in  | opcode, body_index, pos_x, pos_y, vel_x, vel_y, mass  | valid & ready
// res     | out | out_index, new_pos/accel/new_vel x,y, last           | valid & ready
//
// a load writes one body; a step runs all pairs, then the updates; output can stall it
// the pair unit sets the step time: a serial square root and divide for each pair
// state lives in two body/acceleration memories with one read and one write port,
// uninitialized after reset
// reset restores time_step 0.1 and softening 10, no clearing pass
// cmd is taken only between steps; each result waits in the output register for res.ready
module nbody_gravity_euler_step_core
    import nbg_pkg::*;
#(
    parameter int NUM_BODIES = NUM_BODIES_DEF
)
(
    input logic       clk,
    input logic       rst_n,
    nbg_cfg_if.sink   cfg,
    nbg_in_if.sink    cmd,
    nbg_out_if.source res
);

    localparam int IDX_W    = $clog2(NUM_BODIES);
    localparam int CNT_W    = $clog2(NUM_BODIES + 1);
    localparam int LAST_OUT = ((NUM_BODIES < OUT_LIMIT) ? NUM_BODIES : OUT_LIMIT) - 1;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_RD_I   = 11'b000_0000_0010,
        S_LAT_I  = 11'b000_0000_0100,
        S_NEXT_J = 11'b000_0000_1000,
        S_LAT_J  = 11'b000_0001_0000,
        S_PAIR   = 11'b000_0010_0000,
        S_ACC_WR = 11'b000_0100_0000,
        S_RD2    = 11'b000_1000_0000,
        S_MUL    = 11'b001_0000_0000,
        S_SUM    = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  i_reg, i_next, j_reg, j_next;
    logic [DT_W-1:0]   dt_reg;
    logic [SOFT_W-1:0] soft_reg;

    logic signed [63:0] sx_reg, sy_reg;
    logic signed [31:0] pix_reg, piy_reg;
    logic signed [49:0] prod_px_reg, prod_py_reg, prod_vx_reg, prod_vy_reg;

    logic [IDX_IN_W-1:0] out_index_reg;
    logic signed [31:0]  out_px_reg, out_py_reg, out_ax_reg, out_ay_reg;
    logic signed [31:0]  out_vx_reg, out_vy_reg;
    logic                out_last_reg;

    logic             body_wr_en, body_rd_en, acc_wr_en, acc_rd_en;
    logic [IDX_W-1:0] body_wr_addr, body_rd_addr;
    body_t            body_wr_data, body_rd_data;
    accel_t           acc_wr_data, acc_rd_data;

    logic       pair_start;
    pair_req_t  pair_req;
    pair_stat_t pair_stat;
    pair_res_t  pair_res;

    logic cmd_xfer;
    assign cmd_xfer = cmd.valid && cmd.ready;

    nbg_body_mem #(.NUM_BODIES(NUM_BODIES)) u_body_mem (
        .clk     (clk),
        .wr_en   (body_wr_en),
        .wr_addr (body_wr_addr),
        .wr_data (body_wr_data),
        .rd_en   (body_rd_en),
        .rd_addr (body_rd_addr),
        .rd_data (body_rd_data)
    );

    nbg_accel_mem #(.NUM_BODIES(NUM_BODIES)) u_accel_mem (
        .clk     (clk),
        .wr_en   (acc_wr_en),
        .wr_addr (i_reg[IDX_W-1:0]),
        .wr_data (acc_wr_data),
        .rd_en   (acc_rd_en),
        .rd_addr (i_reg[IDX_W-1:0]),
        .rd_data (acc_rd_data)
    );

    assign pair_req.pix  = pix_reg;
    assign pair_req.piy  = piy_reg;
    assign pair_req.pjx  = body_rd_data.pos_x;
    assign pair_req.pjy  = body_rd_data.pos_y;
    assign pair_req.mass = body_rd_data.mass;

    nbg_pair_unit u_pair (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (pair_start),
        .req       (pair_req),
        .softening (soft_reg),
        .stat      (pair_stat),
        .res       (pair_res)
    );

    // euler update
    logic signed [17:0] dt_s;
    logic signed [49:0] mul_px, mul_py, mul_vx, mul_vy;
    logic signed [63:0] px_w, py_w, vx_w, vy_w;
    logic signed [31:0] px_sat, py_sat, vx_sat, vy_sat;

    assign dt_s   = $signed({1'b0, dt_reg});
    assign mul_px = 50'(body_rd_data.vel_x) * 50'(dt_s);
    assign mul_py = 50'(body_rd_data.vel_y) * 50'(dt_s);
    assign mul_vx = 50'(acc_rd_data.acc_x) * 50'(dt_s);
    assign mul_vy = 50'(acc_rd_data.acc_y) * 50'(dt_s);
    assign px_w   = 64'(body_rd_data.pos_x) + 64'(prod_px_reg >>> 16);
    assign py_w   = 64'(body_rd_data.pos_y) + 64'(prod_py_reg >>> 16);
    assign vx_w   = 64'(body_rd_data.vel_x) + 64'(prod_vx_reg >>> 16);
    assign vy_w   = 64'(body_rd_data.vel_y) + 64'(prod_vy_reg >>> 16);
    assign px_sat = sat32(px_w);
    assign py_sat = sat32(py_w);
    assign vx_sat = sat32(vx_w);
    assign vy_sat = sat32(vy_w);

    logic last_body, out_body;
    assign last_body = i_reg == CNT_W'(NUM_BODIES - 1);
    assign out_body  = int'(i_reg) < OUT_LIMIT;

    always_comb
    begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        body_wr_en   = 1'b0;
        body_wr_addr = i_reg[IDX_W-1:0];
        body_wr_data = body_rd_data;
        body_rd_en   = 1'b0;
        body_rd_addr = i_reg[IDX_W-1:0];
        acc_wr_en    = 1'b0;
        acc_rd_en    = 1'b0;
        acc_wr_data.acc_x = sat32(sx_reg);
        acc_wr_data.acc_y = sat32(sy_reg);
        pair_start   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_xfer)
                begin
                    if (cmd.opcode == OP_STEP)
                    begin
                        i_next     = '0;
                        state_next = S_RD_I;
                    end
                    else if (int'(cmd.body_index) < NUM_BODIES)
                    begin
                        body_wr_en         = 1'b1;
                        body_wr_addr       = IDX_W'(cmd.body_index);
                        body_wr_data.pos_x = cmd.pos_x;
                        body_wr_data.pos_y = cmd.pos_y;
                        body_wr_data.vel_x = cmd.vel_x;
                        body_wr_data.vel_y = cmd.vel_y;
                        body_wr_data.mass  = cmd.mass;
                    end
                end
            end
            S_RD_I:
            begin
                body_rd_en = 1'b1;
                state_next = S_LAT_I;
            end
            S_LAT_I:
            begin
                j_next     = '0;
                state_next = S_NEXT_J;
            end
            S_NEXT_J:
            begin
                if (j_reg == CNT_W'(NUM_BODIES))
                    state_next = S_ACC_WR;
                else if (j_reg == i_reg)
                    j_next = j_reg + CNT_W'(1);
                else
                begin
                    body_rd_en   = 1'b1;
                    body_rd_addr = j_reg[IDX_W-1:0];
                    state_next   = S_LAT_J;
                end
            end
            S_LAT_J:
            begin
                pair_start = 1'b1;
                state_next = S_PAIR;
            end
            S_PAIR:
            begin
                if (pair_stat.done)
                begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_NEXT_J;
                end
            end
            S_ACC_WR:
            begin
                acc_wr_en = 1'b1;
                if (last_body)
                begin
                    i_next     = '0;
                    state_next = S_RD2;
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_RD_I;
                end
            end
            S_RD2:
            begin
                body_rd_en = 1'b1;
                acc_rd_en  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: state_next = S_SUM;
            S_SUM:
            begin
                body_wr_en         = 1'b1;
                body_wr_data.pos_x = px_sat;
                body_wr_data.pos_y = py_sat;
                body_wr_data.vel_x = vx_sat;
                body_wr_data.vel_y = vy_sat;
                if (out_body)
                    state_next = S_OUT;
                else if (last_body)
                begin
                    i_next     = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_RD2;
                end
            end
            S_OUT:
            begin
                if (res.ready)
                begin
                    if (last_body)
                    begin
                        i_next     = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + CNT_W'(1);
                        state_next = S_RD2;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            dt_reg    <= DT_RESET;
            soft_reg  <= SOFT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg_reg_t'(cfg.index))
                    REG_TIME_STEP: dt_reg   <= cfg.data[DT_W-1:0];
                    REG_SOFTENING: soft_reg <= cfg.data[SOFT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_LAT_I:
            begin
                pix_reg <= body_rd_data.pos_x;
                piy_reg <= body_rd_data.pos_y;
                sx_reg  <= '0;
                sy_reg  <= '0;
            end
            S_PAIR:
            begin
                if (pair_stat.done)
                begin
                    sx_reg <= sx_reg + 64'($signed(pair_res.term_x));
                    sy_reg <= sy_reg + 64'($signed(pair_res.term_y));
                end
            end
            S_MUL:
            begin
                prod_px_reg <= mul_px;
                prod_py_reg <= mul_py;
                prod_vx_reg <= mul_vx;
                prod_vy_reg <= mul_vy;
            end
            S_SUM:
            begin
                out_index_reg <= IDX_IN_W'(i_reg);
                out_px_reg    <= px_sat;
                out_py_reg    <= py_sat;
                out_ax_reg    <= acc_rd_data.acc_x;
                out_ay_reg    <= acc_rd_data.acc_y;
                out_vx_reg    <= vx_sat;
                out_vy_reg    <= vy_sat;
                out_last_reg  <= int'(i_reg) == LAST_OUT;
            end
            default: ;
        endcase
    end

    assign cmd.ready     = state_reg == S_IDLE;
    assign cfg.ready     = 1'b1;
    assign res.valid     = state_reg == S_OUT;
    assign res.out_index = out_index_reg;
    assign res.new_pos_x = out_px_reg;
    assign res.new_pos_y = out_py_reg;
    assign res.accel_x   = out_ax_reg;
    assign res.accel_y   = out_ay_reg;
    assign res.new_vel_x = out_vx_reg;
    assign res.new_vel_y = out_vy_reg;
    assign res.last      = out_last_reg;

`ifndef SYNTHESIS
    a_no_cmd_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.ready && res.valid))
        else $error("command taken while a result is pending");

    a_pair_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pair_start |-> !pair_stat.busy)
        else $error("pair unit started while busy");

    a_body_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (i_reg < CNT_W'(NUM_BODIES)))
        else $error("body counter out of range");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.last) |-> (int'(res.out_index) == LAST_OUT))
        else $error("last marker on wrong body");
`endif

endmodule
